### sv/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// shared codes, types and pixel unpack function of the targa run-length
// pixel decoder
// ----------------------------------------------------------------------------
package tga_pkg;

    localparam int DATA_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_W    = 32;
    localparam int FMT_W      = 3;
    localparam int KIND_W     = 2;
    localparam int RUN_W      = 8;
    localparam int BIDX_W     = 2;
    localparam int PIX_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PIXELS  = 2'd3;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_GRAY8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_GRAY16 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB15  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGB16  = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGB24  = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RGB32  = 3'd5;

    // packet state
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAW    = 2'd2;

    localparam logic [DATA_W-1:0] HEADER_BIAS = 8'd127;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef struct packed {
        rgba_t            pixel;
        logic [RUN_W-1:0] run_length;
        logic             last_pixel;
        logic             data_error;
    } result_t;

    function automatic logic [2:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_GRAY8:                       n = 3'd1;
            FMT_GRAY16, FMT_RGB15, FMT_RGB16: n = 3'd2;
            FMT_RGB24:                       n = 3'd3;
            default:                         n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic rgba_t unpack(input logic [FMT_W-1:0] fmt,
                                     input logic             alpha_on,
                                     input logic [PIX_W-1:0] px);
        rgba_t      o;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = px[7:0];
        b1 = px[15:8];
        b2 = px[23:16];
        b3 = px[31:24];
        unique case (fmt)
            FMT_GRAY8:
            begin
                o = '{red: b0, green: b0, blue: b0, alpha: 8'hff};
            end
            FMT_GRAY16:
            begin
                o = '{red: b0, green: b0, blue: b0, alpha: alpha_on ? b1 : 8'hff};
            end
            FMT_RGB15, FMT_RGB16:
            begin
                o.blue  = widen5(b0[4:0]);
                o.green = widen5({b1[1:0], b0[7:5]});
                o.red   = widen5(b1[6:2]);
                o.alpha = 8'hff;
                if (fmt == FMT_RGB16 && alpha_on)
                begin
                    o.alpha = b1[7] ? 8'hff : 8'h00;
                end
            end
            FMT_RGB24:
            begin
                o = '{red: b2, green: b1, blue: b0, alpha: 8'hff};
            end
            default:
            begin
                o = '{red: b2, green: b1, blue: b0, alpha: alpha_on ? b3 : 8'hff};
            end
        endcase
        return o;
    endfunction

endpackage

### sv/tga_in_if.sv
// ----------------------------------------------------------------------------
// tga_in_if
// byte stream channel into the decoder
// ----------------------------------------------------------------------------
interface tga_in_if;
    logic                       valid;
    logic                       ready;
    logic [tga_pkg::DATA_W-1:0] data_byte;
    logic                       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

### sv/tga_out_if.sv
// ----------------------------------------------------------------------------
// tga_out_if
// decoded pixel channel out of the decoder
// ----------------------------------------------------------------------------
interface tga_out_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [7:0]                alpha;
    logic [tga_pkg::RUN_W-1:0] run_length;
    logic                      last_pixel;
    logic                      data_error;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output run_length, output last_pixel, output data_error, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input run_length, input last_pixel, input data_error, output ready);
endinterface

### sv/tga_cfg_if.sv
// ----------------------------------------------------------------------------
// tga_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface tga_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tga_pkg::CFG_IDX_W-1:0]  index;
    logic [tga_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/tga_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// targa run-length pixel decoder: bytes in, rgba8 pixels with run counts out
// ----------------------------------------------------------------------------
// Takes one data byte per cycle with no bubbles, as long as the result side
// keeps taking transfers. Each byte sits in an input register, is decoded by
// one pass of logic (packet header parse, byte gather, pixel unpack, pixel
// count update) and any result is registered in the result register, which
// holds it until the result side takes the transfer.
// A stalled result register holds the input side once the input register is
// also full. Configuration writes are always taken and must only be made
// while the decoder is idle.
module tga_rle_pixel_decoder_core
(
    input  logic      clk,
    input  logic      rst_n,
    tga_in_if.sink    data_in,
    tga_out_if.source pixel_out,
    tga_cfg_if.sink   cfg
);

    // configuration
    logic                              compressed_reg;
    logic [tga_pkg::FMT_W-1:0]         pixel_format_reg;
    logic                              alpha_present_reg;
    logic [tga_pkg::COUNT_W-1:0]       image_pixels_reg;

    // input register
    logic                              in_valid_reg;
    logic [tga_pkg::DATA_W-1:0]        in_byte_reg;
    logic                              in_end_reg;

    // decode state
    logic [tga_pkg::KIND_W-1:0]        kind_reg;
    logic [tga_pkg::KIND_W-1:0]        kind_next;
    logic [tga_pkg::RUN_W-1:0]         left_reg;
    logic [tga_pkg::RUN_W-1:0]         left_next;
    logic [tga_pkg::BIDX_W-1:0]        bidx_reg;
    logic [tga_pkg::BIDX_W-1:0]        bidx_next;
    logic [tga_pkg::PIX_W-1:0]         bytes_reg;
    logic [tga_pkg::PIX_W-1:0]         bytes_next;
    logic [tga_pkg::COUNT_W-1:0]       done_reg;
    logic [tga_pkg::COUNT_W-1:0]       done_next;

    // result register
    logic                              out_valid_reg;
    tga_pkg::result_t                  out_reg;
    tga_pkg::result_t                  out_next;
    logic                              emit;

    logic                              advance;
    logic                              proc;
    logic                              active;
    logic                              repeat_pkt;
    logic                              last_rep;
    logic                              complete;
    logic [2:0]                        count;
    logic [tga_pkg::PIX_W-1:0]         gathered;
    logic [tga_pkg::COUNT_W-1:0]       remaining;
    logic [tga_pkg::COUNT_W-1:0]       done_plus_one;
    logic [tga_pkg::COUNT_W-1:0]       done_plus_left;

    assign advance       = !out_valid_reg || pixel_out.ready;
    assign proc          = in_valid_reg && advance;
    assign data_in.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_reg    <= 1'b1;
            pixel_format_reg  <= tga_pkg::FMT_RGB24;
            alpha_present_reg <= 1'b0;
            image_pixels_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tga_pkg::REG_COMPRESSED:    compressed_reg    <= cfg.data[0];
                tga_pkg::REG_PIXEL_FORMAT:  pixel_format_reg  <= cfg.data[tga_pkg::FMT_W-1:0];
                tga_pkg::REG_ALPHA_PRESENT: alpha_present_reg <= cfg.data[0];
                tga_pkg::REG_IMAGE_PIXELS:  image_pixels_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (data_in.valid && data_in.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_in.valid && data_in.ready)
        begin
            in_byte_reg <= data_in.data_byte;
            in_end_reg  <= data_in.end_of_data;
        end
    end

    // decode
    assign active         = done_reg < image_pixels_reg;
    assign remaining      = image_pixels_reg - done_reg;
    assign done_plus_one  = done_reg + 32'd1;
    assign done_plus_left = done_reg + {24'd0, left_reg};
    assign repeat_pkt     = compressed_reg && kind_reg == tga_pkg::KIND_REPEAT;
    assign last_rep       = remaining <= {24'd0, left_reg};
    assign count          = {1'b0, bidx_reg} + 3'd1;
    assign complete       = count >= tga_pkg::bytes_per_pixel(pixel_format_reg);
    assign gathered       = bytes_reg | ({24'd0, in_byte_reg} << {bidx_reg, 3'b000});

    always_comb
    begin
        kind_next  = kind_reg;
        left_next  = left_reg;
        bidx_next  = bidx_reg;
        bytes_next = bytes_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        out_next   = '0;
        if (active)
        begin
            if (compressed_reg && kind_reg == tga_pkg::KIND_HEADER)
            begin
                if (in_byte_reg[7])
                begin
                    kind_next = tga_pkg::KIND_REPEAT;
                    left_next = in_byte_reg - tga_pkg::HEADER_BIAS;
                end
                else
                begin
                    kind_next = tga_pkg::KIND_RAW;
                    left_next = in_byte_reg + 8'd1;
                end
                bidx_next  = '0;
                bytes_next = '0;
            end
            else if (complete)
            begin
                emit           = 1'b1;
                out_next.pixel = tga_pkg::unpack(pixel_format_reg, alpha_present_reg,
                                                 gathered);
                if (repeat_pkt)
                begin
                    kind_next = tga_pkg::KIND_HEADER;
                    left_next = '0;
                    if (last_rep)
                    begin
                        out_next.run_length = remaining[tga_pkg::RUN_W-1:0];
                        out_next.last_pixel = 1'b1;
                        done_next           = image_pixels_reg;
                    end
                    else
                    begin
                        out_next.run_length = left_reg;
                        done_next           = done_plus_left;
                    end
                end
                else
                begin
                    if (compressed_reg)
                    begin
                        if (left_reg > 8'd1)
                        begin
                            left_next = left_reg - 8'd1;
                        end
                        else
                        begin
                            left_next = '0;
                            kind_next = tga_pkg::KIND_HEADER;
                        end
                    end
                    out_next.run_length = 8'd1;
                    out_next.last_pixel = remaining == 32'd1;
                    done_next           = done_plus_one;
                end
                bidx_next  = '0;
                bytes_next = '0;
            end
            else
            begin
                bidx_next  = count[tga_pkg::BIDX_W-1:0];
                bytes_next = gathered;
            end
        end
        if (in_end_reg)
        begin
            if (active && !(emit && out_next.last_pixel))
            begin
                emit                = 1'b1;
                out_next            = '0;
                out_next.data_error = 1'b1;
            end
            kind_next  = tga_pkg::KIND_HEADER;
            left_next  = '0;
            bidx_next  = '0;
            bytes_next = '0;
            done_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= tga_pkg::KIND_HEADER;
            left_reg  <= '0;
            bidx_reg  <= '0;
            bytes_reg <= '0;
            done_reg  <= '0;
        end
        else if (proc)
        begin
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            bidx_reg  <= bidx_next;
            bytes_reg <= bytes_next;
            done_reg  <= done_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.red        = out_reg.pixel.red;
    assign pixel_out.green      = out_reg.pixel.green;
    assign pixel_out.blue       = out_reg.pixel.blue;
    assign pixel_out.alpha      = out_reg.pixel.alpha;
    assign pixel_out.run_length = out_reg.run_length;
    assign pixel_out.last_pixel = out_reg.last_pixel;
    assign pixel_out.data_error = out_reg.data_error;

`ifndef SYNTH
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.data_error |->
            out_reg.run_length == 8'd0 && !out_reg.last_pixel)
        else $error("error result carries a run or last flag");

    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.data_error |->
            out_reg.run_length != 8'd0 && out_reg.run_length <= 8'd128)
        else $error("pixel result run length out of range");

    a_header_empty: assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg == tga_pkg::KIND_HEADER |-> left_reg == 8'd0)
        else $error("packet count left over while expecting header");

    a_gather_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bidx_reg == 2'd0 |-> bytes_reg == 32'd0)
        else $error("stale pixel bytes with empty gather");
`endif

endmodule
